@@ hw/rtl/looping_pcm_resample_mixer_assert.svh @@
// Assertion macros for the looping PCM resample mixer.
// Taken in by `include from the files that carry concurrent assertions.
`ifndef LOOPING_PCM_RESAMPLE_MIXER_ASSERT_SVH
`define LOOPING_PCM_RESAMPLE_MIXER_ASSERT_SVH

// Property checked on every rising edge, switched off while reset is low.
`define LPRM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property checked on every rising edge, reset included.
`define LPRM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ hw/rtl/lprm_pkg.sv @@
// Shared types and constants of the looping PCM resample mixer.
// No dependencies; the RTL modules and interfaces refer to it by scoped names, the testbench files import it.
`timescale 1ns / 1ps

package lprm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_MIX   = 2'd3
  } lprm_cmd_e;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ADDR_IN_W  = 16;
  localparam int unsigned FRAME_W    = 2 * SAMPLE_W;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_FRAME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP         = 2'd2;

  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned LOOP_W  = 16;
  localparam int unsigned STEP_W  = 20;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'h1_0000;

  // Integer part of the read cursor.
  localparam int unsigned INT_W = 18;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Stage control from the top level to each interpolation lane.
  typedef struct packed {
    logic adv;
    logic play;
  } lprm_lane_ctrl_t;

endpackage

@@ hw/rtl/lprm_if.sv @@
// Valid/ready channel interfaces of the looping PCM resample mixer.
// Depends on lprm_pkg for the field widths.
`timescale 1ns / 1ps

interface lprm_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [lprm_pkg::CMD_W-1:0]           command;
  logic [lprm_pkg::ADDR_IN_W-1:0]       frame_address;
  logic signed [lprm_pkg::SAMPLE_W-1:0] sample_left;
  logic signed [lprm_pkg::SAMPLE_W-1:0] sample_right;

  modport source (output valid, command, frame_address, sample_left, sample_right,
                  input ready);
  modport sink   (input valid, command, frame_address, sample_left, sample_right,
                  output ready);
endinterface

interface lprm_mix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lprm_pkg::SAMPLE_W-1:0] mixed_left;
  logic signed [lprm_pkg::SAMPLE_W-1:0] mixed_right;

  modport source (output valid, mixed_left, mixed_right, input ready);
  modport sink   (input valid, mixed_left, mixed_right, output ready);
endinterface

@@ hw/rtl/looping_pcm_resample_mixer.sv @@
// Looping stereo PCM track player with linear-interpolation resampling.
// Depends on lprm_pkg, lprm_if, lprm_track_ram and lprm_interp_lane.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle on s_cmd while it holds
// s_cmd.ready high: writes fill the track RAM, start and stop arm and disarm
// playback, and each mix transaction returns one output frame on m_mix
// (track RAM read at the accepting edge, then the interpolation multiply
// register, then rounding, dry-sample add and saturation into the output
// register). The cursor wrap and advance are done in the cycle of
// acceptance, so mixes follow each other back to back; the two RAM read ports
// fetch both interpolation frames at once. An output register and per-stage
// valid bits let up to three mix results queue while m_mix is stalled. The
// track RAM is not cleared: a frame must be written before playback reads it.
// MAX_FRAMES must be a power of two.
module looping_pcm_resample_mixer #(
  parameter int unsigned MAX_FRAMES = 65536,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lprm_cmd_if.sink                          s_cmd,
  lprm_mix_if.source                        m_mix,
  input  logic                              cfg_we_i,
  input  logic [lprm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lprm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned ADDR_W  = $clog2(MAX_FRAMES);
  localparam int unsigned INT_W   = lprm_pkg::INT_W;
  localparam int unsigned POS_W   = INT_W + FRAC_BITS;
  localparam int unsigned TOTAL_W = lprm_pkg::TOTAL_W;
  localparam int unsigned LOOP_W  = lprm_pkg::LOOP_W;
  localparam int unsigned STEP_W  = lprm_pkg::STEP_W;
  localparam int unsigned SW      = lprm_pkg::SAMPLE_W;

  // Configuration and playback state.
  logic [TOTAL_W-1:0] total_q;
  logic [LOOP_W-1:0]  loop_q;
  logic [STEP_W-1:0]  step_q;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   pos_d;
  logic               playing_q;
  logic               playing_d;

  // Pipeline control.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_free, s1_free;
  logic s1_adv, s2_adv;
  logic in_fire, mix_fire, write_fire;

  // Stage 1 payload (alongside the RAM read data).
  logic                 s1_play_q;
  logic [FRAC_BITS-1:0] s1_frac_q;
  logic signed [SW-1:0] s1_dry_l_q;
  logic signed [SW-1:0] s1_dry_r_q;

  logic signed [SW-1:0] out_l_q;
  logic signed [SW-1:0] out_r_q;

  // Cursor arithmetic.
  logic [TOTAL_W-1:0] loop_eff;
  logic [TOTAL_W-1:0] span;
  logic               play_now;
  logic               past_end;
  logic               still_past;
  logic [POS_W-1:0]   pos_sub;
  logic [POS_W-1:0]   pos_wr;
  logic [POS_W-1:0]   pos_next;
  logic [INT_W-1:0]   idx0;
  logic [INT_W-1:0]   idx0_inc;
  logic [INT_W-1:0]   idx1;

  logic [lprm_pkg::FRAME_W-1:0] rd0;
  logic [lprm_pkg::FRAME_W-1:0] rd1;
  logic signed [SW-1:0]         lane_l;
  logic signed [SW-1:0]         lane_r;
  lprm_pkg::lprm_lane_ctrl_t    lane_ctrl;

  assign out_free = !out_valid_q || m_mix.ready;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign s1_adv   = s1_valid_q && s2_free;
  assign s2_adv   = s2_valid_q && out_free;

  assign s_cmd.ready = s1_free;
  assign in_fire     = s_cmd.valid && s1_free;
  assign mix_fire    = in_fire && (s_cmd.command == lprm_pkg::CMD_MIX);
  assign write_fire  = in_fire && (s_cmd.command == lprm_pkg::CMD_WRITE);

  // A loop point at or beyond the track end falls back to frame zero.
  assign loop_eff = ({1'b0, loop_q} < total_q) ? {1'b0, loop_q} : '0;
  assign span     = total_q - loop_eff;
  assign play_now = playing_q && (total_q != '0);

  assign past_end   = pos_q[POS_W-1:FRAC_BITS] >= {1'b0, total_q};
  assign pos_sub    = pos_q - {1'b0, span, {FRAC_BITS{1'b0}}};
  assign still_past = pos_sub[POS_W-1:FRAC_BITS] >= {1'b0, total_q};

  always_comb begin
    if (!past_end) begin
      pos_wr = pos_q;
    end else if (still_past) begin
      pos_wr = {1'b0, loop_eff, {FRAC_BITS{1'b0}}};
    end else begin
      pos_wr = pos_sub;
    end
  end

  assign idx0     = pos_wr[POS_W-1:FRAC_BITS];
  assign idx0_inc = idx0 + INT_W'(1);
  assign idx1     = (idx0_inc >= {1'b0, total_q}) ? {1'b0, loop_eff} : idx0_inc;
  assign pos_next = pos_wr + POS_W'(step_q);

  always_comb begin
    pos_d     = pos_q;
    playing_d = playing_q;
    if (in_fire) begin
      case (s_cmd.command)
        lprm_pkg::CMD_START: begin
          pos_d     = '0;
          playing_d = (total_q != '0);
        end
        lprm_pkg::CMD_STOP: begin
          pos_d     = '0;
          playing_d = 1'b0;
        end
        lprm_pkg::CMD_MIX: begin
          if (play_now) begin
            pos_d = pos_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      loop_q    <= '0;
      step_q    <= lprm_pkg::STEP_RESET;
      pos_q     <= '0;
      playing_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      playing_q <= playing_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          lprm_pkg::REG_TOTAL_FRAMES: total_q <= cfg_data_i[TOTAL_W-1:0];
          lprm_pkg::REG_LOOP_FRAME:   loop_q  <= cfg_data_i[LOOP_W-1:0];
          lprm_pkg::REG_STEP:         step_q  <= cfg_data_i[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mix_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_mix.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_fire) begin
      s1_play_q  <= play_now;
      s1_frac_q  <= pos_wr[FRAC_BITS-1:0];
      s1_dry_l_q <= s_cmd.sample_left;
      s1_dry_r_q <= s_cmd.sample_right;
    end
    if (s2_adv) begin
      out_l_q <= lane_l;
      out_r_q <= lane_r;
    end
  end

  lprm_track_ram #(
    .DEPTH  (MAX_FRAMES),
    .ADDR_W (ADDR_W)
  ) u_track_ram (
    .clk_i    (clk_i),
    .we_i     (write_fire),
    .waddr_i  (ADDR_W'(s_cmd.frame_address)),
    .wdata_i  ({s_cmd.sample_right, s_cmd.sample_left}),
    .re_i     (mix_fire),
    .raddr0_i (ADDR_W'(idx0)),
    .raddr1_i (ADDR_W'(idx1)),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  assign lane_ctrl.adv  = s1_adv;
  assign lane_ctrl.play = s1_play_q;

  lprm_interp_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .frame0_i (rd0[SW-1:0]),
    .frame1_i (rd1[SW-1:0]),
    .frac_i   (s1_frac_q),
    .dry_i    (s1_dry_l_q),
    .mixed_o  (lane_l)
  );

  lprm_interp_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .frame0_i (rd0[2*SW-1:SW]),
    .frame1_i (rd1[2*SW-1:SW]),
    .frac_i   (s1_frac_q),
    .dry_i    (s1_dry_r_q),
    .mixed_o  (lane_r)
  );

  assign m_mix.valid       = out_valid_q;
  assign m_mix.mixed_left  = out_l_q;
  assign m_mix.mixed_right = out_r_q;

endmodule

@@ hw/rtl/lprm_track_ram.sv @@
// Track memory: one write port and two registered read ports.
// Depends on lprm_pkg for the frame width.
`timescale 1ns / 1ps

module lprm_track_ram #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [ADDR_W-1:0]                waddr_i,
  input  logic [lprm_pkg::FRAME_W-1:0]     wdata_i,
  input  logic                             re_i,
  input  logic [ADDR_W-1:0]                raddr0_i,
  input  logic [ADDR_W-1:0]                raddr1_i,
  output logic [lprm_pkg::FRAME_W-1:0]     rdata0_o,
  output logic [lprm_pkg::FRAME_W-1:0]     rdata1_o
);

  logic [lprm_pkg::FRAME_W-1:0] mem [DEPTH];
  logic [lprm_pkg::FRAME_W-1:0] rdata0_q;
  logic [lprm_pkg::FRAME_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ hw/rtl/lprm_interp_lane.sv @@
// One channel of the interpolator: multiply stage, then rounding toward zero,
// the dry-sample add and saturation. Depends on lprm_pkg.
`timescale 1ns / 1ps

module lprm_interp_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  lprm_pkg::lprm_lane_ctrl_t            ctrl_i,
  input  logic signed [lprm_pkg::SAMPLE_W-1:0] frame0_i,
  input  logic signed [lprm_pkg::SAMPLE_W-1:0] frame1_i,
  input  logic [FRAC_BITS-1:0]                 frac_i,
  input  logic signed [lprm_pkg::SAMPLE_W-1:0] dry_i,
  output logic signed [lprm_pkg::SAMPLE_W-1:0] mixed_o
);

  localparam int unsigned SW     = lprm_pkg::SAMPLE_W;
  localparam int unsigned PROD_W = FRAC_BITS + SW + 2;
  localparam int unsigned NUM_W  = FRAC_BITS + SW + 3;

  logic signed [SW:0]       diff;
  logic signed [PROD_W-1:0] diff_x;
  logic signed [PROD_W-1:0] frac_x;
  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  base;
  logic signed [NUM_W-1:0]  num_d;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [SW-1:0]     dry_q;
  logic                     play_q;
  logic signed [NUM_W-1:0]  bias;
  logic signed [NUM_W-1:0]  adj;
  logic signed [SW:0]       smp;
  logic signed [SW+1:0]     sum;
  logic signed [SW-1:0]     sat;

  assign diff   = {frame1_i[SW-1], frame1_i} - {frame0_i[SW-1], frame0_i};
  assign diff_x = {{(PROD_W-SW-1){diff[SW]}}, diff};
  assign frac_x = {{(PROD_W-FRAC_BITS){1'b0}}, frac_i};
  assign prod   = diff_x * frac_x;
  assign base   = {{3{frame0_i[SW-1]}}, frame0_i, {FRAC_BITS{1'b0}}};
  assign num_d  = base + {prod[PROD_W-1], prod};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      num_q  <= num_d;
      dry_q  <= dry_i;
      play_q <= ctrl_i.play;
    end
  end

  // Adding 2^F - 1 to a negative numerator makes the arithmetic shift
  // truncate toward zero rather than toward minus infinity.
  assign bias = num_q[NUM_W-1] ? {{(NUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0;
  assign adj  = num_q + bias;
  assign smp  = adj[FRAC_BITS+SW:FRAC_BITS];
  assign sum  = {{2{dry_q[SW-1]}}, dry_q} + {smp[SW], smp};

  always_comb begin
    if (sum[SW+1:SW-1] == 3'b000 || sum[SW+1:SW-1] == 3'b111) begin
      sat = sum[SW-1:0];
    end else if (sum[SW+1]) begin
      sat = lprm_pkg::SAMPLE_MIN;
    end else begin
      sat = lprm_pkg::SAMPLE_MAX;
    end
  end

  assign mixed_o = play_q ? sat : dry_q;

endmodule

@@ hw/rtl/lprm_checker.sv @@
// Port-level assertions for the looping PCM resample mixer, bound to the top.
// Depends on lprm_pkg and looping_pcm_resample_mixer_assert.svh.
`timescale 1ns / 1ps
`include "looping_pcm_resample_mixer_assert.svh"

module lprm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic [lprm_pkg::CMD_W-1:0]           in_command_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [lprm_pkg::SAMPLE_W-1:0] out_left_i,
  input logic signed [lprm_pkg::SAMPLE_W-1:0] out_right_i
);

  // A stalled result keeps its values until it is taken.
  `LPRM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_left_i) && $stable(out_right_i))

  // With the output register empty the whole pipeline can move, so input is taken.
  `LPRM_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_i |-> in_ready_i)

  // A taken mix transaction reaches the output when m_mix stays ready while it moves through the pipeline.
  `LPRM_ASSERT(a_mix_latency, clk_i, rst_ni, in_valid_i && in_ready_i && (in_command_i == lprm_pkg::CMD_MIX) ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)

  // No result is shown on the first edge after reset is released.
  `LPRM_ASSERT_ALWAYS(a_empty_after_reset, clk_i, rst_ni && $past(!rst_ni) |-> !out_valid_i)

endmodule

bind looping_pcm_resample_mixer lprm_checker u_lprm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (s_cmd.valid),
  .in_ready_i   (s_cmd.ready),
  .in_command_i (s_cmd.command),
  .out_valid_i  (m_mix.valid),
  .out_ready_i  (m_mix.ready),
  .out_left_i   (m_mix.mixed_left),
  .out_right_i  (m_mix.mixed_right)
);

@@ tb/sv/lprm_mix_checker.sv @@
// Scoreboard for the looping PCM resample mixer: follows the command, result and
// configuration traffic, predicts every mixed frame and compares it field by field.
// Depends on lprm_pkg and on the channel interfaces of lprm_if.
`timescale 1ns / 1ps

module lprm_mix_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lprm_cmd_if                             cmd_mon,
  lprm_mix_if                             mix_mon,
  input  logic                            cfg_we_i,
  input  logic [lprm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lprm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import lprm_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } mix_frame_t;

  // Shadow copy of the block's registers and playback state.
  logic [TOTAL_W-1:0]        total_q;
  logic [LOOP_W-1:0]         loop_q;
  logic [STEP_W-1:0]         step_q;
  logic [INT_W+FRAC-1:0]     cursor_q;
  logic                      playing_q;
  logic [FRAME_W-1:0]        track_q [0:65535];

  mix_frame_t                mixed_frames_q [$];
  mix_frame_t                want_frame;

  task automatic report_mismatch(string what, int want_v, int got_v);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t: mismatch on %s at result %0d: expected %0d, got %0d",
               $realtime, what, checked_o, want_v, got_v);
    end
    fail_count_o++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] add_saturated(logic signed [SAMPLE_W-1:0] dry,
                                                               longint wet);
    longint sum;
    sum = longint'(dry) + wet;
    if (sum > 32767) return SAMPLE_MAX;
    if (sum < -32768) return SAMPLE_MIN;
    return sum[SAMPLE_W-1:0];
  endfunction

  // Linear blend of two neighbouring samples; the division truncates toward zero.
  function automatic longint blend(logic signed [SAMPLE_W-1:0] s0, logic signed [SAMPLE_W-1:0] s1,
                                   logic [FRAC-1:0] frac);
    longint num;
    num = longint'(s0) * (longint'(1) << FRAC) + (longint'(s1) - longint'(s0)) * longint'(frac);
    return num / (longint'(1) << FRAC);
  endfunction

  function automatic mix_frame_t predict_mix(logic signed [SAMPLE_W-1:0] dry_l,
                                             logic signed [SAMPLE_W-1:0] dry_r);
    mix_frame_t       res;
    logic [TOTAL_W-1:0] loop_eff;
    logic [INT_W-1:0] idx0;
    logic [INT_W-1:0] idx1;
    logic [FRAME_W-1:0] f0;
    logic [FRAME_W-1:0] f1;
    res.left  = dry_l;
    res.right = dry_r;
    if (playing_q && total_q != '0) begin
      loop_eff = ({1'b0, loop_q} < total_q) ? {1'b0, loop_q} : '0;
      idx0 = cursor_q[INT_W+FRAC-1:FRAC];
      if (idx0 >= total_q) begin
        // Jump back by one loop span; if that is not enough, restart at the loop frame.
        cursor_q = cursor_q - ({{(INT_W+FRAC-TOTAL_W){1'b0}}, total_q - loop_eff} << FRAC);
        idx0 = cursor_q[INT_W+FRAC-1:FRAC];
        if (idx0 >= total_q) begin
          idx0 = loop_eff;
          cursor_q = {loop_eff, {FRAC{1'b0}}};
        end
      end
      idx1 = idx0 + 1'b1;
      if (idx1 >= total_q) idx1 = loop_eff;
      f0 = track_q[idx0[15:0]];
      f1 = track_q[idx1[15:0]];
      res.left  = add_saturated(dry_l, blend(f0[15:0], f1[15:0], cursor_q[FRAC-1:0]));
      res.right = add_saturated(dry_r, blend(f0[31:16], f1[31:16], cursor_q[FRAC-1:0]));
      cursor_q = cursor_q + step_q;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      = '0;
      loop_q       = '0;
      step_q       = STEP_RESET;
      cursor_q     = '0;
      playing_q    = 1'b0;
      mixed_frames_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TOTAL_FRAMES: total_q = cfg_data_i[TOTAL_W-1:0];
          REG_LOOP_FRAME:   loop_q  = cfg_data_i[LOOP_W-1:0];
          REG_STEP:         step_q  = cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end

      if (cmd_mon.valid && cmd_mon.ready) begin
        case (cmd_mon.command)
          CMD_WRITE: track_q[cmd_mon.frame_address] = {cmd_mon.sample_right, cmd_mon.sample_left};
          CMD_START: begin
            cursor_q  = '0;
            playing_q = (total_q != '0);
          end
          CMD_STOP: begin
            cursor_q  = '0;
            playing_q = 1'b0;
          end
          CMD_MIX: mixed_frames_q.push_back(predict_mix(cmd_mon.sample_left, cmd_mon.sample_right));
          default: ;
        endcase
      end

      if (mix_mon.valid && mix_mon.ready) begin
        if (mixed_frames_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 0, int'(mix_mon.mixed_left));
        end else begin
          want_frame = mixed_frames_q.pop_front();
          if (mix_mon.mixed_left !== want_frame.left)
            report_mismatch("mixed_left", int'(want_frame.left), int'(mix_mon.mixed_left));
          if (mix_mon.mixed_right !== want_frame.right)
            report_mismatch("mixed_right", int'(want_frame.right), int'(mix_mon.mixed_right));
        end
        checked_o++;
      end

      pending_o = mixed_frames_q.size();
    end
  end

endmodule

@@ tb/sv/looping_pcm_resample_mixer_tb.sv @@
// Top of the looping PCM resample mixer testbench: clock, reset, stimulus and verdict.
// Depends on lprm_pkg, lprm_if, the block itself and the lprm_mix_checker scoreboard.
`timescale 1ns / 1ps

module looping_pcm_resample_mixer_tb;
  import lprm_pkg::*;

  localparam int unsigned HOLD_OFF       = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASES         = 14;
  localparam int unsigned PHASE_ITEMS    = 90;
  localparam int unsigned BIG_TRACK      = 1024;
  localparam logic [STEP_W-1:0] STEP_MAX = 20'hF_FFFF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  lprm_cmd_if cmd_if ();
  lprm_mix_if mix_if ();

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;

  looping_pcm_resample_mixer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_cmd       (cmd_if),
    .m_mix       (mix_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  lprm_mix_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon      (cmd_if),
    .mix_mon      (mix_if),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Frames that hold defined data; playback is only ever pointed at these.
  bit written_q [0:65535];
  int burst_left = 0;
  int items_sent = 0;
  int configs    = 0;

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(0, 4))
      0: return 20'd1;
      1: return STEP_MAX;
      2: return 20'($urandom_range(1, STEP_MAX));
      default: return 20'($urandom_range(20'h0_4000, 20'h2_8000));
    endcase
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_item(lprm_cmd_e cmd, logic [15:0] addr, logic [15:0] left,
                           logic [15:0] right);
    if (burst_left == 0) burst_left = $urandom_range(1, 40);
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= cmd;
    cmd_if.frame_address <= addr;
    cmd_if.sample_left   <= left;
    cmd_if.sample_right  <= right;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (cmd == CMD_WRITE) written_q[addr] = 1'b1;
    burst_left--;
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (HOLD_OFF) @(negedge clk_i);
  endtask

  task automatic load_config(int total, int loop_at, logic [STEP_W-1:0] step_by);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOTAL_FRAMES;
    cfg_data  <= CFG_DATA_W'(total);
    @(negedge clk_i);
    cfg_index <= REG_LOOP_FRAME;
    cfg_data  <= CFG_DATA_W'(loop_at);
    @(negedge clk_i);
    cfg_index <= REG_STEP;
    cfg_data  <= step_by;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    configs++;
  endtask

  task automatic fill_unwritten(int upto);
    for (int a = 0; a < upto; a++) begin
      if (!written_q[a]) send_item(CMD_WRITE, 16'(a), rand_sample(), rand_sample());
    end
  endtask

  task automatic run_phase_body(int n, int total);
    int pick;
    logic [15:0] addr;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        send_item(CMD_MIX, 16'($urandom()), rand_sample(), rand_sample());
      end else if (pick < 84) begin
        if (total > 0 && $urandom_range(0, 1) == 1) addr = 16'($urandom_range(0, total - 1));
        else addr = 16'($urandom());
        send_item(CMD_WRITE, addr, rand_sample(), rand_sample());
      end else if (pick < 94) begin
        send_item(CMD_START, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      end else begin
        send_item(CMD_STOP, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      end
    end
  endtask

  // Result side: stretches of steady readiness, random stalls, a fixed pattern and long stalls.
  initial begin
    int mode;
    int left;
    int stall;
    mix_if.ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 200);
      while (left > 0) begin
        @(negedge clk_i);
        case (mode)
          0: mix_if.ready <= 1'b1;
          1: mix_if.ready <= 1'($urandom_range(0, 1));
          2: mix_if.ready <= (left % 4 == 0);
          default: begin
            if (stall == 0) begin
              mix_if.ready <= 1'b1;
              stall = $urandom_range(1, 10);
            end else begin
              mix_if.ready <= 1'b0;
              stall--;
            end
          end
        endcase
        left--;
      end
    end
  end

  // Ends the run when no transaction of any kind has happened for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (mix_if.valid && mix_if.ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding", quiet, pending);
    $display("looping_pcm_resample_mixer_tb: done, errors");
    $finish;
  end

  initial begin
    int t;
    int lp;
    logic [STEP_W-1:0] st;
    longint reach;
    bit big;
    cmd_if.valid         = 1'b0;
    cmd_if.command       = CMD_WRITE;
    cmd_if.frame_address = '0;
    cmd_if.sample_left   = '0;
    cmd_if.sample_right  = '0;
    cfg_we               = 1'b0;
    cfg_index            = REG_TOTAL_FRAMES;
    cfg_data             = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: four frames, loop to zero, one and a half frames per output frame.
    load_config(4, 0, 20'h1_8000);
    send_item(CMD_WRITE, 16'd0, 16'h7FFF, 16'h8000);
    send_item(CMD_WRITE, 16'd1, 16'h8000, 16'h7FFF);
    send_item(CMD_WRITE, 16'd2, 16'h0000, 16'hFFFF);
    send_item(CMD_WRITE, 16'd3, 16'h1234, 16'hEDCC);
    send_item(CMD_WRITE, 16'hFFFF, 16'h5555, 16'hAAAA);
    // Not yet started, so the frame must come back untouched.
    send_item(CMD_MIX, 16'hFFFF, 16'h7FFF, 16'h8000);
    send_item(CMD_START, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_MIX, 16'h0000, 16'h7FFF, 16'h7FFF);
    send_item(CMD_MIX, 16'h0000, 16'h8000, 16'h8000);
    // The second frame lies past the end and is taken from the loop point.
    send_item(CMD_MIX, 16'h0000, 16'h0000, 16'h0000);
    // Wrap to half way between full scale positive and negative: truncates to zero.
    send_item(CMD_MIX, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_MIX, 16'h0000, 16'h7FFF, 16'h8000);
    send_item(CMD_MIX, 16'h0000, 16'h0001, 16'hFFFF);
    send_item(CMD_WRITE, 16'd2, 16'h8000, 16'h7FFF);
    send_item(CMD_MIX, 16'h0000, 16'hC000, 16'h4000);
    send_item(CMD_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_MIX, 16'h0000, 16'h8000, 16'h7FFF);
    send_item(CMD_START, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_MIX, 16'h0000, 16'h7FFF, 16'h8000);

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin t = 1; lp = 0; st = 20'd1; end
        1: begin t = 0; lp = $urandom_range(0, 65535); st = rand_step(); end
        2: begin t = 37; lp = 65535; st = STEP_MAX; end
        3: begin t = 65536; lp = 65535; st = 20'($urandom_range(20'h0_8000, 20'h3_0000)); end
        4: begin t = 3; lp = 2; st = STEP_MAX; end
        5: begin t = $urandom_range(1, 64); lp = $urandom_range(0, t - 1); st = STEP_RESET; end
        9: begin
          t  = $urandom_range(2000, 65535);
          lp = $urandom_range(0, 65535);
          st = 20'($urandom_range(1, 20'h3_0000));
        end
        default: begin
          t  = $urandom_range(1, 64);
          lp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, t - 1);
          st = rand_step();
        end
      endcase
      load_config(t, lp, st);
      big = (t > BIG_TRACK);
      if (big) begin
        // Only the frames that the cursor can reach from zero within this phase are filled.
        send_item(CMD_STOP, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        reach = ((longint'(PHASE_ITEMS) * longint'(st)) >> 16) + 2;
        fill_unwritten((reach < t) ? int'(reach) : t);
      end else begin
        fill_unwritten(t);
        // The first two phases keep the previous playback running across the change; later phases usually restart it.
        if (p > 1 && $urandom_range(0, 9) < 7)
          send_item(CMD_START, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      end
      run_phase_body(PHASE_ITEMS, t);
    end

    wait_idle();
    $display("ran %0d command transactions under %0d register settings", items_sent, configs);
    $display("compared %0d mixed frames, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("looping_pcm_resample_mixer_tb: done, clean");
    end else begin
      $display("looping_pcm_resample_mixer_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lprm_pkg.sv
hw/rtl/lprm_if.sv
hw/rtl/lprm_track_ram.sv
hw/rtl/lprm_interp_lane.sv
hw/rtl/looping_pcm_resample_mixer.sv
hw/rtl/lprm_checker.sv
tb/sv/lprm_mix_checker.sv
tb/sv/looping_pcm_resample_mixer_tb.sv
